// ===== rtl/core/sit_pkg.sv =====
// Shared constants for the sorted index table.
package sit_pkg;
    localparam int DefCapacity = 256;

    localparam logic [2:0] MODE_READ   = 3'd0;
    localparam logic [2:0] MODE_SEARCH = 3'd1;
    localparam logic [2:0] MODE_APPEND = 3'd2;
    localparam logic [2:0] MODE_INSERT = 3'd3;
    localparam logic [2:0] MODE_REMOVE = 3'd4;
    localparam logic [2:0] MODE_CLEAR  = 3'd5;
    localparam logic [2:0] MODE_INCR   = 3'd6;
    localparam logic [2:0] MODE_SUB    = 3'd7;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
endpackage

// ===== rtl/core/sit_ram.sv =====
// Generic single-port RAM with a registered read.
module sit_ram #(
    parameter int Width = 32,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== rtl/core/sorted_index_table_unit.sv =====
// Sorted index table: a RAM of ascending entries walked by one small sequencer.
// A read presents its address and then takes the data; a search makes one memory probe
// per step of a binary search; shifts and range updates read and rewrite each entry
// moved or touched in turn, one at a time through the single RAM port.
// One item is in work at a time; the next item is taken once its result transfers.
// Synchronous active-low reset empties the table; the entry RAM is not cleared.
module sorted_index_table_unit
    import sit_pkg::*;
#(
    parameter int CAPACITY = DefCapacity
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_mode,
    input  logic [8:0]  i_position,
    input  logic [31:0] i_value,
    input  logic [31:0] i_amount,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_status,
    output logic [31:0] o_read_value,
    output logic        o_found,
    output logic        o_below_valid,
    output logic [7:0]  o_below_position,
    output logic        o_above_valid,
    output logic [7:0]  o_above_position,
    output logic [8:0]  o_entry_count
);
    localparam int AW = $clog2(CAPACITY);
    // Counts must hold CAPACITY and the 9-bit position.
    localparam int CW = (AW + 1 > 10) ? AW + 1 : 10;
    localparam logic [CW-1:0] CapC = CW'(CAPACITY);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RADDR = 3'd1;  // address presented, waiting on RAM
    localparam logic [2:0] ST_RDATA = 3'd2;  // read data valid
    localparam logic [2:0] ST_FILL = 3'd3;   // write the inserted run
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [2:0]    r_mode;
    logic [CW-1:0] r_pos, r_cnt, r_fill, r_idx, r_lo, r_hi, r_end;
    logic [31:0]   r_val, r_amt;
    logic          r_ovalid, r_status, r_found, r_bv, r_av;
    logic [31:0]   r_rv;
    logic [7:0]    r_bp, r_ap;

    // The RAM is driven by one address and one write per cycle.
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_wdata, ram_rdata;

    sit_ram #(.Width(32), .Depth(CAPACITY)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    logic          acc;
    logic [CW-1:0] in_pos, mid, amt_c;
    logic          amt_big;
    logic [CW:0]   sum_lh;

    assign acc     = i_valid && !o_stall;
    assign o_stall = (r_state != ST_IDLE) || r_ovalid;
    assign in_pos  = CW'(i_position);
    assign amt_big = (r_amt > 32'(CAPACITY));
    assign amt_c   = amt_big ? CapC : CW'(r_amt);
    assign sum_lh  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = sum_lh[CW:1];

    // The address depends on the phase of the walk: probes use mid, moves use r_idx, appends use the fill count.
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_idx[AW-1:0];
        ram_wdata = r_val;
        if (r_state == ST_RADDR && r_mode == MODE_SEARCH) begin
            ram_addr = mid[AW-1:0];
        end else if (r_state == ST_RDATA) begin
            case (r_mode)
                MODE_INSERT: begin
                    ram_we    = 1'b1;
                    ram_addr  = AW'(r_idx + amt_c);
                    ram_wdata = ram_rdata;
                end
                MODE_REMOVE: begin
                    ram_we    = 1'b1;
                    ram_addr  = AW'(r_idx - amt_c);
                    ram_wdata = ram_rdata;
                end
                MODE_INCR: begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata + 32'd1;
                end
                MODE_SUB: begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata - r_amt;
                end
                default: ;
            endcase
        end else if (r_state == ST_FILL) begin
            ram_we    = 1'b1;
            ram_wdata = r_val;
        end else if (r_state == ST_IDLE && acc && i_mode == MODE_APPEND &&
                     r_fill < CapC) begin
            ram_we    = 1'b1;
            ram_addr  = r_fill[AW-1:0];
            ram_wdata = i_value;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: n_state = r_state;
            ST_RADDR: n_state = ST_RDATA;
            default: n_state = r_state;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (acc) begin
                        r_mode <= i_mode; r_pos <= in_pos; r_val <= i_value;
                        r_amt <= i_amount;
                        r_status <= 1'b0; r_rv <= '0; r_found <= 1'b0;
                        r_bv <= 1'b0; r_av <= 1'b0; r_bp <= '0; r_ap <= '0;
                        r_state <= ST_DONE;
                        r_lo <= '0; r_hi <= r_fill - 1'b1;
                        case (i_mode)
                            MODE_READ: begin
                                if (in_pos < r_fill) begin
                                    r_idx <= in_pos; r_state <= ST_RADDR;
                                end else begin
                                    r_status <= 1'b1; r_rv <= ALL_ONES;
                                end
                            end
                            MODE_SEARCH: begin
                                if (r_fill != '0) r_state <= ST_RADDR;
                            end
                            MODE_APPEND: begin
                                if (r_fill < CapC) r_fill <= r_fill + 1'b1;
                                else r_status <= 1'b1;
                            end
                            MODE_INSERT: begin
                                if (in_pos > r_fill ||
                                    {1'b0, i_amount} + 33'(r_fill) > 33'(CAPACITY)) begin
                                    r_status <= 1'b1;
                                end else if (i_amount != '0) begin
                                    // Shift the tail up, walking down from the top.
                                    r_end <= r_fill + CW'(i_amount);
                                    if (r_fill > in_pos) begin
                                        r_idx <= r_fill - 1'b1; r_state <= ST_RADDR;
                                    end else begin
                                        r_idx <= in_pos; r_cnt <= '0; r_state <= ST_FILL;
                                    end
                                end
                            end
                            MODE_REMOVE: begin
                                if (i_amount == '0 ||
                                    {1'b0, i_amount} + 33'(in_pos) > 33'(r_fill)) begin
                                    r_status <= 1'b1;
                                end else begin
                                    r_idx <= in_pos + CW'(i_amount);
                                    r_end <= r_fill - CW'(i_amount);
                                    if (in_pos + CW'(i_amount) < r_fill) r_state <= ST_RADDR;
                                    else r_fill <= r_fill - CW'(i_amount);
                                end
                            end
                            MODE_CLEAR: r_fill <= '0;
                            default: begin
                                r_idx <= in_pos;
                                if (in_pos < r_fill) r_state <= ST_RADDR;
                            end
                        endcase
                    end
                end
                ST_RADDR: r_state <= n_state;
                ST_RDATA: begin
                    r_state <= ST_RADDR;
                    case (r_mode)
                        MODE_READ: begin
                            r_rv <= ram_rdata; r_state <= ST_DONE;
                        end
                        MODE_SEARCH: begin
                            if (r_val > ram_rdata) begin
                                r_lo <= mid + 1'b1;
                                if (mid + 1'b1 > r_hi) begin
                                    r_state <= ST_DONE;
                                    r_bv <= 1'b1; r_bp <= 8'(r_hi);
                                    r_av <= (mid + 1'b1 < r_fill);
                                    r_ap <= (mid + 1'b1 < r_fill) ? 8'(mid + 1'b1) : '0;
                                end
                            end else if (r_val < ram_rdata) begin
                                r_hi <= mid - 1'b1;
                                if (mid == r_lo) begin
                                    r_state <= ST_DONE;
                                    r_bv <= (mid != '0); r_bp <= (mid != '0) ? 8'(mid - 1'b1) : '0;
                                    r_av <= 1'b1; r_ap <= 8'(r_lo);
                                end
                            end else begin
                                r_found <= 1'b1; r_bv <= 1'b1; r_av <= 1'b1;
                                r_bp <= 8'(mid); r_ap <= 8'(mid); r_state <= ST_DONE;
                            end
                        end
                        MODE_INSERT: begin
                            if (r_idx == r_pos) begin
                                r_idx <= r_pos; r_cnt <= '0; r_state <= ST_FILL;
                            end else r_idx <= r_idx - 1'b1;
                        end
                        MODE_REMOVE: begin
                            if (r_idx + 1'b1 >= r_fill) begin
                                r_fill <= r_end; r_state <= ST_DONE;
                            end else r_idx <= r_idx + 1'b1;
                        end
                        default: begin
                            if (r_idx + 1'b1 >= r_fill) r_state <= ST_DONE;
                            else r_idx <= r_idx + 1'b1;
                        end
                    endcase
                end
                ST_FILL: begin
                    r_val <= r_val + 32'd1;
                    r_idx <= r_idx + 1'b1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt + 1'b1 == amt_c) begin
                        r_fill <= r_end; r_state <= ST_DONE;
                    end
                end
                default: begin
                    r_ovalid <= 1'b1; r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_ovalid;
    assign o_status         = r_status;
    assign o_read_value     = r_rv;
    assign o_found          = r_found;
    assign o_below_valid    = r_bv;
    assign o_below_position = r_bp;
    assign o_above_valid    = r_av;
    assign o_above_position = r_ap;
    assign o_entry_count    = 9'(r_fill);

    // The fill count never exceeds the capacity.
    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CapC) else $error("fill count above capacity");
    // A held result is not replaced while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && i_stall |=> r_ovalid) else $error("result dropped");
    // No item is taken while a result waits.
    a_no_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> o_stall) else $error("accepted over pending result");
    // A match always reports both neighbours valid.
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_found |-> r_bv && r_av && r_bp == r_ap)
        else $error("inconsistent match");
endmodule
